/* design/apfd_pkg.sv */
`default_nettype none

package apfd_pkg;

  localparam int ORDER = 4;

  localparam int NumCfg   = 8;
  localparam int CfgIdxW  = 3;
  localparam int NumCoef  = ORDER + 1;
  localparam int CoefIdxW = (NumCoef > 1) ? $clog2(NumCoef) : 1;
  localparam int StIdxW   = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int LastCnt  = 2 * ORDER + 1;
  localparam int CntW     = $clog2(LastCnt + 1);

  localparam int SampleW  = 24;
  localparam int CoefW    = 32;
  localparam int StateW   = 48;
  localparam int ProdW    = CoefW + SampleW;
  localparam int AccW     = 64;
  localparam int OutShift = 24;
  localparam int StShift  = 15;

  localparam logic signed [CoefW-1:0] CoefOne = CoefW'(32'sd16777216);

  typedef logic [CoefIdxW-1:0] coef_idx_t;
  typedef logic [StIdxW-1:0]   st_idx_t;
  typedef logic [CntW-1:0]     cnt_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_OUT   = 2'd1,
    ACC_LOAD  = 2'd2,
    ACC_STATE = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic      x_load;
    coef_idx_t mul_coef;
    logic      mul_use_y;
    acc_op_e   acc_op;
    st_idx_t   st_idx;
    logic      st_zero;
    logic      out_push;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

/* design/apfd_ctrl.sv */
`default_nettype none

module apfd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire apfd_pkg::status_t status_i,
  output apfd_pkg::cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;
  apfd_pkg::cnt_t cnt_q, cnt_d;

  always_comb begin
    int t;
    int u;
    int k;
    t = int'(cnt_q);
    u = t - 1;
    k = 0;
    state_d = state_q;
    cnt_d = cnt_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.acc_op = apfd_pkg::ACC_NONE;

    // The multiplier works on step cnt while the accumulator finishes step cnt-1.
    if (t == 0 || t >= apfd_pkg::LastCnt) begin
      cmd_o.mul_coef = apfd_pkg::coef_idx_t'(apfd_pkg::ORDER);
      cmd_o.mul_use_y = 1'b0;
    end else if (t[0]) begin
      k = (t - 1) >> 1;
      cmd_o.mul_coef = apfd_pkg::coef_idx_t'(apfd_pkg::ORDER - 1 - k);
      cmd_o.mul_use_y = 1'b0;
    end else begin
      k = (t >> 1) - 1;
      cmd_o.mul_coef = apfd_pkg::coef_idx_t'(k + 1);
      cmd_o.mul_use_y = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.x_load = 1'b1;
          cnt_d = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (u == 0) begin
          cmd_o.acc_op = apfd_pkg::ACC_OUT;
        end else if (u > 0 && u[0]) begin
          k = (u - 1) >> 1;
          cmd_o.acc_op = apfd_pkg::ACC_LOAD;
          cmd_o.st_idx = apfd_pkg::st_idx_t'(k + 1);
          cmd_o.st_zero = (k + 1 == apfd_pkg::ORDER);
        end else if (u > 0) begin
          k = (u >> 1) - 1;
          cmd_o.acc_op = apfd_pkg::ACC_STATE;
          cmd_o.st_idx = apfd_pkg::st_idx_t'(k);
        end
        if (cnt_q == apfd_pkg::cnt_t'(apfd_pkg::LastCnt)) begin
          if (status_i.slot_free) begin
            cmd_o.out_push = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end else begin
          cnt_d = cnt_q + apfd_pkg::cnt_t'(1);
        end
      end
      S_HOLD: begin
        if (status_i.slot_free) begin
          cmd_o.out_push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* design/apfd_datapath.sv */
`default_nettype none

module apfd_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire apfd_pkg::cmd_t                        cmd_i,
  output apfd_pkg::status_t                          status_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [apfd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [apfd_pkg::CoefW-1:0]            cfg_data_i,
  input  wire logic signed [apfd_pkg::SampleW-1:0]   sample_in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [apfd_pkg::SampleW-1:0]        sample_out_o,
  output logic                                       clipped_o
);

  localparam int SW = apfd_pkg::SampleW;
  localparam int CW = apfd_pkg::CoefW;
  localparam int TW = apfd_pkg::StateW;
  localparam int PW = apfd_pkg::ProdW;
  localparam int AW = apfd_pkg::AccW;
  localparam int OS = apfd_pkg::OutShift;
  localparam int TS = apfd_pkg::StShift;
  localparam int RoW = AW - OS;
  localparam int RsW = AW - TS;

  localparam logic signed [SW-1:0] OutMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] OutMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [TW-1:0] StMax  = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] StMin  = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [AW-1:0] OutRound = AW'(1) <<< (OS - 1);
  localparam logic signed [AW-1:0] StRound  = AW'(1) <<< (TS - 1);

  logic signed [CW-1:0] coef_q [apfd_pkg::NumCoef];
  logic signed [TW-1:0] state_q [apfd_pkg::ORDER];
  logic signed [SW-1:0] x_q, y_q;
  logic                 clip_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] sample_out_q;
  logic                 clipped_q;

  logic signed [SW-1:0] mul_smp;
  logic signed [PW-1:0] prod_d;
  logic signed [AW-1:0] prod_ext, st0_ext, rd_ext, out_sum, st_diff;
  logic signed [TW-1:0] rd_state;
  logic signed [RoW-1:0] out_r;
  logic signed [RsW-1:0] st_r;
  logic                 out_ok, st_ok;
  logic signed [SW-1:0] y_d;
  logic signed [TW-1:0] st_d;
  logic                 slot_free;

  assign mul_smp = cmd_i.mul_use_y ? y_q : x_q;
  assign prod_d = coef_q[cmd_i.mul_coef] * mul_smp;
  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};

  assign st0_ext = {{(AW-TW-TS){state_q[0][TW-1]}}, state_q[0], {TS{1'b0}}};
  assign rd_state = cmd_i.st_zero ? '0 : state_q[cmd_i.st_idx];
  assign rd_ext = {{(AW-TW-TS){rd_state[TW-1]}}, rd_state, {TS{1'b0}}} | StRound;

  assign out_sum = prod_ext + st0_ext + OutRound;
  assign out_r = out_sum[AW-1:OS];
  assign out_ok = (out_r[RoW-1:SW-1] == {(RoW-SW+1){out_r[RoW-1]}});
  assign y_d = out_ok ? out_r[SW-1:0] : (out_r[RoW-1] ? OutMin : OutMax);

  assign st_diff = acc_q - prod_ext;
  assign st_r = st_diff[AW-1:TS];
  assign st_ok = (st_r[RsW-1:TW-1] == {(RsW-TW+1){st_r[RsW-1]}});
  assign st_d = st_ok ? st_r[TW-1:0] : (st_r[RsW-1] ? StMin : StMax);

  assign slot_free = !out_valid_q || out_ready_i;
  assign status_o.slot_free = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apfd_pkg::NumCoef; i++) begin
        coef_q[i] <= (i == 0) ? apfd_pkg::CoefOne : '0;
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < apfd_pkg::NumCoef)) begin
      coef_q[cfg_idx_i[apfd_pkg::CoefIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apfd_pkg::ORDER; i++) begin
        state_q[i] <= '0;
      end
    end else if (cmd_i.acc_op == apfd_pkg::ACC_STATE) begin
      state_q[cmd_i.st_idx] <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.x_load) begin
      x_q <= sample_in_i;
    end
    case (cmd_i.acc_op)
      apfd_pkg::ACC_OUT: begin
        y_q <= y_d;
        clip_q <= !out_ok;
      end
      apfd_pkg::ACC_LOAD: begin
        acc_q <= prod_ext + rd_ext;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_push) begin
      sample_out_q <= y_q;
      clipped_q <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o = clipped_q;

endmodule

`default_nettype wire

/* design/allpass_fractional_delay_filter.sv */
// The filter takes a new input item only after the result of the last one has been pushed
// into the output register. The single shared 32x24 multiplier forms the 2*ORDER+1 products
// of each item one per cycle.
// Reset: coef_0 is one, all other coefficients and all state words are zero,
// and the output register is empty.
`default_nettype none

module allpass_fractional_delay_filter (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [apfd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [apfd_pkg::CoefW-1:0]            cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [apfd_pkg::SampleW-1:0]   sample_in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [apfd_pkg::SampleW-1:0]        sample_out_o,
  output logic                                       clipped_o
);

  apfd_pkg::cmd_t    cmd;
  apfd_pkg::status_t status;

  apfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  apfd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  a_push_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_push |-> status.slot_free)
    else $error("result pushed into a full output register");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new item taken while the previous one is in work");

  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_push))
    else $error("output valid without a pushed result");

endmodule

`default_nettype wire

/* bench/allpass_fractional_delay_filter_test.sv */
`timescale 1ns / 1ps

module allpass_fractional_delay_filter_test;

  localparam int     Pause        = 2 * apfd_pkg::ORDER + 6;
  localparam int     WatchLimit   = 4000;
  localparam int     HoldCycles   = 300;
  localparam int     NumPhases    = 6;
  localparam int     ItemsPerPhase = 170;
  localparam longint OutMax = 64'sd8388607;
  localparam longint OutMin = -64'sd8388608;
  localparam longint StMax  = (64'sd1 <<< 47) - 1;
  localparam longint StMin  = -(64'sd1 <<< 47);
  localparam logic signed [apfd_pkg::SampleW-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [apfd_pkg::SampleW-1:0] SampleMin = 24'sh800000;

  class allpass_chain;
    typedef struct {
      logic signed [apfd_pkg::SampleW-1:0] sample;
      logic                                clipped;
    } filt_out_t;

    longint    coef[apfd_pkg::NumCfg];
    longint    dstate[apfd_pkg::ORDER];
    filt_out_t expected_out[$];
    int        errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      coef[0] = longint'(apfd_pkg::CoefOne);
      foreach (dstate[i]) dstate[i] = 0;
      errors = 0;
    endfunction

    function void set_coef(int idx, logic [apfd_pkg::CoefW-1:0] val);
      coef[idx] = longint'($signed(val));
    endfunction

    function longint limit_to(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void push_sample(logic signed [apfd_pkg::SampleW-1:0] x);
      longint    xs;
      longint    acc;
      longint    r;
      longint    y;
      filt_out_t e;
      xs = longint'(x);
      acc = coef[apfd_pkg::ORDER] * xs + dstate[0] * 32768;
      r = (acc + (64'sd1 <<< 23)) >>> 24;
      y = limit_to(r, OutMin, OutMax);
      e.sample = y[apfd_pkg::SampleW-1:0];
      e.clipped = (y != r);
      for (int k = 0; k < apfd_pkg::ORDER - 1; k++) begin
        acc = coef[apfd_pkg::ORDER-1-k] * xs - coef[k+1] * y + dstate[k+1] * 32768;
        dstate[k] = limit_to((acc + 16384) >>> 15, StMin, StMax);
      end
      acc = coef[0] * xs - coef[apfd_pkg::ORDER] * y;
      dstate[apfd_pkg::ORDER-1] = limit_to((acc + 16384) >>> 15, StMin, StMax);
      expected_out.push_back(e);
    endfunction

    function void check_output(logic signed [apfd_pkg::SampleW-1:0] s, logic c);
      filt_out_t e;
      if (expected_out.size() == 0) begin
        $error("unexpected item: sample_out %0d clipped %0b", s, c);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      if (s !== e.sample) begin
        $error("sample_out mismatch: expected %0d, actual %0d", e.sample, s);
        errors++;
      end
      if (c !== e.clipped) begin
        $error("clipped mismatch: expected %0b, actual %0b", e.clipped, c);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [apfd_pkg::CfgIdxW-1:0]        cfg_idx = '0;
  logic [apfd_pkg::CoefW-1:0]          cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [apfd_pkg::SampleW-1:0] sample_in = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [apfd_pkg::SampleW-1:0] sample_out;
  logic                                clipped;

  allpass_chain               sb;
  logic [apfd_pkg::CoefW-1:0] coef_plan[apfd_pkg::NumCfg];
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;
  int                         hold_asked = 0;
  int                         hold_seen = 0;
  int                         hold_left = 0;
  int                         quiet_cycles = 0;

  allpass_fractional_delay_filter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out),
    .clipped_o   (clipped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asked) begin
        hold_seen++;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(sample_out, clipped);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("allpass_fractional_delay_filter_test: errors");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic signed [apfd_pkg::SampleW-1:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.push_sample(x);
  endtask

  task automatic load_coefs();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (Pause) @(posedge clk);
    for (int i = 0; i < apfd_pkg::NumCfg; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[apfd_pkg::CfgIdxW-1:0];
      cfg_data <= coef_plan[i];
      @(posedge clk);
      sb.set_coef(i, coef_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [apfd_pkg::SampleW-1:0] pick_sample();
    logic signed [apfd_pkg::SampleW-1:0] s;
    case ($urandom_range(0, 9))
      0: s = SampleMax;
      1: s = SampleMin;
      2: s = apfd_pkg::SampleW'($urandom_range(0, 511)) - apfd_pkg::SampleW'(256);
      default: s = apfd_pkg::SampleW'($urandom());
    endcase
    return s;
  endfunction

  function automatic logic [apfd_pkg::CoefW-1:0] pick_small_coef();
    return apfd_pkg::CoefW'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset coefficients the filter is a pure delay of ORDER items.
    send_sample('0);
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    repeat (apfd_pkg::ORDER) send_sample('0);

    // Largest coefficients drive the output into saturation and feed the
    // clipped value back.
    foreach (coef_plan[i]) coef_plan[i] = 32'h7FFFFFFF;
    load_coefs();
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMax);
    send_sample('0);
    send_sample('0);
    foreach (coef_plan[i]) coef_plan[i] = 32'h80000000;
    load_coefs();
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(SampleMin);
    send_sample('0);

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 3)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        1: foreach (coef_plan[i]) coef_plan[i] = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
        2: foreach (coef_plan[i]) coef_plan[i] = $urandom();
        3: begin
          foreach (coef_plan[i]) coef_plan[i] = $urandom();
          for (int i = 0; i <= apfd_pkg::ORDER; i++) coef_plan[i] = '0;
          coef_plan[0] = apfd_pkg::CoefOne;
        end
        default: begin
          foreach (coef_plan[i]) coef_plan[i] = pick_small_coef();
          coef_plan[0] = apfd_pkg::CoefOne + pick_small_coef();
        end
      endcase
      load_coefs();
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == 40 && (p == 1 || p == 4)) hold_asked++;
        send_sample(pick_sample());
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (Pause) @(posedge clk);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("allpass_fractional_delay_filter_test: clean");
    end else begin
      $display("allpass_fractional_delay_filter_test: errors");
    end
    $finish;
  end

endmodule
